/* rtl/c3f_pkg.sv */
package c3f_pkg;

    // Sizes of the line store and of the arithmetic.
    localparam int MAX_WIDTH      = 1024;
    localparam int COEF_FRAC_BITS = 8;
    localparam int ADDR_W         = $clog2(MAX_WIDTH);
    localparam int WEFF_W         = $clog2(MAX_WIDTH + 1);
    localparam int NCH            = 3;
    localparam int NCELL          = 3;
    localparam int COEF_W         = 12;
    localparam int PROD_W         = 21;
    localparam int PSUM_W         = 22;
    localparam int SUM_W          = 24;
    localparam int CFG_W          = 36;
    localparam int BIAS_W         = 9;
    localparam int WIDTH_W        = 11;
    localparam int ROW_W          = 12;
    localparam int OUT_COL_W      = 10;
    localparam int PIX_MAX        = 255;
    localparam int MIN_DIM        = 3;

    // Register reset values: identity kernel, full-size frame.
    localparam logic [CFG_W-1:0]   COEF_TOP_RST = 36'h0_0000_0000;
    localparam logic [CFG_W-1:0]   COEF_MID_RST = 36'h0_0010_0000;
    localparam logic [CFG_W-1:0]   COEF_BOT_RST = 36'h0_0000_0000;
    localparam logic [WIDTH_W-1:0] WIDTH_RST    = 11'd1024;
    localparam logic [ROW_W-1:0]   HEIGHT_RST   = 12'd768;

    typedef enum logic [2:0] {
        CFG_COEF_TOP,
        CFG_COEF_MID,
        CFG_COEF_BOT,
        CFG_BIAS,
        CFG_MODE,
        CFG_WIDTH,
        CFG_HEIGHT
    } cfg_idx_t;

    typedef logic [7:0] chan_t;

    // Channel 0 is gray or red, 1 green, 2 blue.
    typedef chan_t [NCH-1:0] pix_t;

    // One column of the 3x3 window.
    typedef struct packed {
        pix_t top;
        pix_t mid;
        pix_t bot;
    } column_t;

    typedef logic signed [COEF_W-1:0] coef_t;

    // The three coefficients of one kernel column.
    typedef struct packed {
        coef_t top;
        coef_t mid;
        coef_t bot;
    } coef_col_t;

    typedef logic signed [PSUM_W-1:0] psum_t;

    // One line store entry: the row two above and the row above.
    typedef struct packed {
        pix_t older;
        pix_t newer;
    } lb_word_t;

    typedef struct packed {
        logic              rd_en;
        logic [ADDR_W-1:0] rd_addr;
        logic              wr_en;
        logic [ADDR_W-1:0] wr_addr;
    } lb_ctrl_t;

    typedef struct packed {
        chan_t chan_a;
        chan_t chan_b;
        chan_t chan_c;
        logic  frame_start;
    } pix_in_t;

    typedef struct packed {
        chan_t                out_a;
        chan_t                out_b;
        chan_t                out_c;
        logic [OUT_COL_W-1:0] out_col;
        logic [ROW_W-1:0]     out_row;
    } res_t;

endpackage

/* rtl/c3f_line_buf.sv */
module c3f_line_buf
    import c3f_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  lb_ctrl_t ctrl,
    input  lb_word_t wr_data,
    output lb_word_t rd_data
);

    lb_word_t          mem [MAX_WIDTH];
    lb_word_t          rd_word_reg;
    logic [ADDR_W-1:0] rd_addr_reg;
    logic [ADDR_W-1:0] last_addr_reg;
    lb_word_t          last_word_reg;
    logic              last_valid_reg;

    // Two-row store: one write and one registered read per cycle.
    always_ff @(posedge clk)
    begin
        if (ctrl.wr_en)
        begin
            mem[ctrl.wr_addr] <= wr_data;
        end
        if (ctrl.rd_en)
        begin
            rd_word_reg <= mem[ctrl.rd_addr];
            rd_addr_reg <= ctrl.rd_addr;
        end
        if (ctrl.wr_en)
        begin
            last_addr_reg <= ctrl.wr_addr;
            last_word_reg <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_valid_reg <= 1'b0;
        end
        else if (ctrl.wr_en)
        begin
            last_valid_reg <= 1'b1;
        end
    end

    // A read that raced the latest write to the same column takes the new word.
    assign rd_data = (last_valid_reg && (last_addr_reg == rd_addr_reg)) ?
                     last_word_reg : rd_word_reg;

endmodule

/* rtl/c3f_win_cell.sv */
module c3f_win_cell
    import c3f_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      shift,
    input  column_t   col_in,
    output column_t   col_out,
    input  coef_col_t coef,
    input  logic      load,
    output psum_t     psum [NCH]
);

    column_t col_reg;
    psum_t   psum_reg  [NCH];
    psum_t   psum_next [NCH];

    // The window column moves one cell to the left with every pixel.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
        end
        else if (shift)
        begin
            col_reg <= col_in;
        end
    end

    // Three taps of this column, summed per channel.
    always_comb
    begin
        logic signed [PROD_W-1:0] p_top;
        logic signed [PROD_W-1:0] p_mid;
        logic signed [PROD_W-1:0] p_bot;
        for (int ch = 0; ch < NCH; ch++)
        begin
            p_top = PROD_W'($signed({1'b0, col_reg.top[ch]})) * PROD_W'(coef.top);
            p_mid = PROD_W'($signed({1'b0, col_reg.mid[ch]})) * PROD_W'(coef.mid);
            p_bot = PROD_W'($signed({1'b0, col_reg.bot[ch]})) * PROD_W'(coef.bot);
            psum_next[ch] = PSUM_W'(p_top) + PSUM_W'(p_mid) + PSUM_W'(p_bot);
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            psum_reg <= psum_next;
        end
    end

    assign col_out = col_reg;
    assign psum    = psum_reg;

endmodule

/* rtl/conv3x3_clamp_filter.sv */
// 3x3 convolution over a raster pixel stream, gray or RGB, with a signed bias
// and a clamp to 0..255. The block takes one pixel per clock for as long as
// the result side keeps up; a result passes the pixel stage, the window cells,
// the kernel sum and the output register, and border pixels give no result beat.
// The rate is set by the line store, a MAX_WIDTH x 48-bit memory that is read and
// written once per pixel, and by the row of three window cells that each shift one
// column per pixel. The store needs no clearing after reset: a frame writes every
// column of a row before it reads it. The user must write coefficients, bias, mode
// and frame size only while the block is idle; the block does not enforce it.
module conv3x3_clamp_filter
    import c3f_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             pix_valid,
    output logic             pix_stall,
    input  pix_in_t          pix,
    output logic             res_valid,
    input  logic             res_stall,
    output res_t             res,
    input  logic             cfg_wr_en,
    input  logic [2:0]       cfg_index,
    input  logic [CFG_W-1:0] cfg_data
);

    typedef struct packed {
        logic [ADDR_W-1:0] col;
        logic [ROW_W-1:0]  row;
    } pos_t;

    // Configuration registers.
    logic [CFG_W-1:0]          coef_top_reg;
    logic [CFG_W-1:0]          coef_mid_reg;
    logic [CFG_W-1:0]          coef_bot_reg;
    logic signed [BIAS_W-1:0]  bias_reg;
    logic                      mode_reg;
    logic [WIDTH_W-1:0]        width_reg;
    logic [ROW_W-1:0]          height_reg;

    // Position and pipeline.
    logic [ADDR_W-1:0]         col_reg;
    logic [ADDR_W-1:0]         col_next;
    logic [ROW_W-1:0]          row_reg;
    logic [ROW_W-1:0]          row_next;
    logic [WEFF_W-1:0]         w_eff;
    logic [ROW_W-1:0]          h_eff;
    logic [ADDR_W-1:0]         c_now;
    logic [ROW_W-1:0]          r_now;
    logic                      emit_now;
    logic                      accept;

    logic                      v1_reg, v2_reg, v3_reg, v4_reg, res_valid_reg;
    logic                      ready1, ready2, ready3, ready4, ready_out;
    logic                      move12, move23, move34, move4o;
    logic                      emit1_reg;
    pix_t                      s1_pix_reg;
    pos_t                      s1_pos_reg, s2_pos_reg, s3_pos_reg, s4_pos_reg;
    logic signed [SUM_W-1:0]   sum_reg  [NCH];
    logic signed [SUM_W-1:0]   sum_next [NCH];
    res_t                      res_reg;
    res_t                      res_next;

    lb_ctrl_t                  lb_ctrl;
    lb_word_t                  lb_wr;
    lb_word_t                  lb_rd;
    column_t                   col_chain [NCELL+1];
    psum_t                     psum_w    [NCELL][NCH];

    // Register writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_top_reg <= COEF_TOP_RST;
            coef_mid_reg <= COEF_MID_RST;
            coef_bot_reg <= COEF_BOT_RST;
            bias_reg     <= '0;
            mode_reg     <= 1'b0;
            width_reg    <= WIDTH_RST;
            height_reg   <= HEIGHT_RST;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_COEF_TOP: coef_top_reg <= cfg_data;
                CFG_COEF_MID: coef_mid_reg <= cfg_data;
                CFG_COEF_BOT: coef_bot_reg <= cfg_data;
                CFG_BIAS:     bias_reg     <= cfg_data[BIAS_W-1:0];
                CFG_MODE:     mode_reg     <= cfg_data[0];
                CFG_WIDTH:    width_reg    <= cfg_data[WIDTH_W-1:0];
                CFG_HEIGHT:   height_reg   <= cfg_data[ROW_W-1:0];
                default:      ;
            endcase
        end
    end

    // Effective frame size.
    always_comb
    begin
        if (width_reg < MIN_DIM)
        begin
            w_eff = WEFF_W'(MIN_DIM);
        end
        else if (width_reg > MAX_WIDTH)
        begin
            w_eff = WEFF_W'(MAX_WIDTH);
        end
        else
        begin
            w_eff = WEFF_W'(width_reg);
        end
        h_eff = (height_reg < MIN_DIM) ? ROW_W'(MIN_DIM) : height_reg;
    end

    // Pipeline flow: each stage moves when the one after it has room.
    assign ready_out = !res_valid_reg || !res_stall;
    assign ready4    = !v4_reg || ready_out;
    assign ready3    = !v3_reg || ready4;
    assign ready2    = !v2_reg || ready3;
    assign ready1    = !v1_reg || ready2;
    assign pix_stall = !ready1;
    assign accept    = pix_valid && ready1;
    assign move12    = v1_reg && ready2;
    assign move23    = v2_reg && ready3;
    assign move34    = v3_reg && ready4;
    assign move4o    = v4_reg && ready_out;

    // Position of the incoming pixel and of the one after it.
    always_comb
    begin
        if (pix.frame_start || (col_reg >= w_eff))
        begin
            c_now = '0;
        end
        else
        begin
            c_now = col_reg;
        end
        if (pix.frame_start || (row_reg >= h_eff))
        begin
            r_now = '0;
        end
        else
        begin
            r_now = row_reg;
        end
        emit_now = (c_now >= ADDR_W'(2)) && (r_now >= ROW_W'(2));
        if (({1'b0, c_now} + 1'b1) >= w_eff)
        begin
            col_next = '0;
            row_next = (({1'b0, r_now} + 1'b1) >= {1'b0, h_eff}) ? '0 : r_now + 1'b1;
        end
        else
        begin
            col_next = c_now + 1'b1;
            row_next = r_now;
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg       <= '0;
            row_reg       <= '0;
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            v4_reg        <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                col_reg <= col_next;
                row_reg <= row_next;
            end
            if (ready1)
            begin
                v1_reg <= pix_valid;
            end
            // Pixels with no result leave the pipeline once they shift the window.
            if (ready2)
            begin
                v2_reg <= v1_reg && emit1_reg;
            end
            if (ready3)
            begin
                v3_reg <= v2_reg;
            end
            if (ready4)
            begin
                v4_reg <= v3_reg;
            end
            if (ready_out)
            begin
                res_valid_reg <= v4_reg;
            end
        end
    end

    // Payload stages.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_pix_reg[0]  <= pix.chan_a;
            s1_pix_reg[1]  <= pix.chan_b;
            s1_pix_reg[2]  <= pix.chan_c;
            s1_pos_reg.col <= c_now;
            s1_pos_reg.row <= r_now;
            emit1_reg      <= emit_now;
        end
        if (move12)
        begin
            s2_pos_reg <= s1_pos_reg;
        end
        if (move23)
        begin
            s3_pos_reg <= s2_pos_reg;
        end
        if (move34)
        begin
            s4_pos_reg <= s3_pos_reg;
            sum_reg    <= sum_next;
        end
        if (move4o)
        begin
            res_reg <= res_next;
        end
    end

    // Line store: read at accept, write back the shifted column on the move.
    assign lb_ctrl.rd_en   = accept;
    assign lb_ctrl.rd_addr = c_now;
    assign lb_ctrl.wr_en   = move12;
    assign lb_ctrl.wr_addr = s1_pos_reg.col;
    assign lb_wr.older     = lb_rd.newer;
    assign lb_wr.newer     = s1_pix_reg;

    c3f_line_buf u_line_buf (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl    (lb_ctrl),
        .wr_data (lb_wr),
        .rd_data (lb_rd)
    );

    // Row of window cells; cell 0 holds the newest (right) column.
    assign col_chain[0].top = lb_rd.older;
    assign col_chain[0].mid = lb_rd.newer;
    assign col_chain[0].bot = s1_pix_reg;

    for (genvar i = 0; i < NCELL; i++)
    begin : g_cell
        localparam int TAP = NCELL - 1 - i;
        coef_col_t cell_coef;

        assign cell_coef.top = coef_top_reg[COEF_W*TAP +: COEF_W];
        assign cell_coef.mid = coef_mid_reg[COEF_W*TAP +: COEF_W];
        assign cell_coef.bot = coef_bot_reg[COEF_W*TAP +: COEF_W];

        c3f_win_cell u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .shift   (move12),
            .col_in  (col_chain[i]),
            .col_out (col_chain[i+1]),
            .coef    (cell_coef),
            .load    (move23),
            .psum    (psum_w[i])
        );
    end

    // Full kernel sum per channel.
    always_comb
    begin
        for (int ch = 0; ch < NCH; ch++)
        begin
            sum_next[ch] = SUM_W'(psum_w[0][ch]) + SUM_W'(psum_w[1][ch]) +
                           SUM_W'(psum_w[2][ch]);
        end
    end

    // Drop the fraction toward zero, add the bias, clamp to 0..255.
    function automatic chan_t finish_chan(input logic signed [SUM_W-1:0] sum,
                                          input logic signed [BIAS_W-1:0] bias);
        localparam int TB_W = SUM_W - COEF_FRAC_BITS + 1;
        localparam logic [SUM_W-1:0] RND_MASK = SUM_W'((1 << COEF_FRAC_BITS) - 1);
        logic signed [SUM_W-1:0] adj;
        logic signed [TB_W-1:0]  tb;
        chan_t                   q;
        adj = sum[SUM_W-1] ? (sum + $signed(RND_MASK)) : sum;
        tb  = TB_W'(adj >>> COEF_FRAC_BITS) + TB_W'(bias);
        if (tb < 0)
        begin
            q = '0;
        end
        else if (tb > PIX_MAX)
        begin
            q = 8'(PIX_MAX);
        end
        else
        begin
            q = tb[7:0];
        end
        return q;
    endfunction

    always_comb
    begin
        logic [ADDR_W-1:0] cm1;
        logic [ROW_W-1:0]  rm1;
        cm1 = s4_pos_reg.col - 1'b1;
        rm1 = s4_pos_reg.row - 1'b1;
        res_next.out_a   = finish_chan(sum_reg[0], bias_reg);
        res_next.out_b   = mode_reg ? finish_chan(sum_reg[1], bias_reg) : '0;
        res_next.out_c   = mode_reg ? finish_chan(sum_reg[2], bias_reg) : '0;
        res_next.out_col = OUT_COL_W'(cm1);
        res_next.out_row = rm1;
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    // An empty output register never holds back the input side.
    a_drain_no_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !res_valid_reg |-> !pix_stall)
        else $error("input stalled while the output register is empty");

    // Every result beat is for an interior center pixel.
    a_interior_only: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> ((res.out_col != '0) && (res.out_row != '0)))
        else $error("result beat for a border pixel");

    // After a pixel the column position stays inside the row.
    a_col_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && !cfg_wr_en) |=> (col_reg < $past(w_eff)))
        else $error("column position ran past the row width");

    // The last window column is never passed on. Columns read from store
    // entries that a new frame has not filled yet may hold unknown bits.
    a_window_tail: assert property (@(posedge clk) disable iff (!rst_n)
        move12 |=> (col_chain[NCELL] === $past(col_chain[NCELL-1])))
        else $error("window column did not shift through the last cell");

endmodule
